FILE: design/wbts_pkg.sv
package wbts_pkg;

	localparam int CNT_W = 23;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WHITE_LEVEL  = 2'd2;

	localparam int CFG_DATA_W = 12;
	localparam int RST_FRAME_WIDTH  = 640;
	localparam int RST_FRAME_HEIGHT = 480;
	localparam logic [7:0] RST_WHITE_LEVEL = 8'd255;

	// floor(w / 3) as (w * RECIP3) >> RECIP3_SHIFT, exact for w below 2^17
	localparam int RECIP3_W = 17;
	localparam logic [RECIP3_W-1:0] RECIP3 = 17'd43691;
	localparam int RECIP3_SHIFT = 17;

	// column band of a pixel
	localparam logic [1:0] REGION_LEFT   = 2'd0;
	localparam logic [1:0] REGION_CENTER = 2'd1;
	localparam logic [1:0] REGION_RIGHT  = 2'd2;

	// steering commands
	localparam logic [1:0] CMD_STOP    = 2'd0;
	localparam logic [1:0] CMD_LEFT    = 2'd1;
	localparam logic [1:0] CMD_RIGHT   = 2'd2;
	localparam logic [1:0] CMD_FORWARD = 2'd3;

	// classified pixel leaving the scan stage
	typedef struct packed {
		logic       valid;
		logic       white;
		logic [1:0] region;
		logic       last;
	} tok_t;

endpackage

FILE: design/white_blob_third_steering_top.sv
// white_blob_third_steering_top
// pixels come in raster order on pix_valid/pix_ready, three channel bytes per
// item. a pixel is white when all three bytes equal white_level; white pixels
// are counted per column band (left third, centre, right third of the row).
// at the last pixel of a frame one result leaves on res_valid/res_ready: the
// steering command and the three counts, which then restart from zero.
// configuration (frame_width, frame_height, white_level) is written on
// cfg_valid with cfg_index and cfg_data; cfg_ready is always high. writes
// belong between frames while the block is idle.
// throughput is one pixel per clock while pix_ready is high: classification,
// the three lane counters and the command merge are separate register stages.
// after the edge that accepts the last pixel of a frame, its result passes
// the totals stage and then the output register, where res_valid rises.
// a stalled receiver holds the result in the output register; pixels keep
// flowing, a second finished frame waits in the totals stage, and pix_ready
// drops only when a third frame ends while those two are still waiting.
// reset clears position, counts and pending results and restores the reset
// frame size 640 x 480 and white level 255.
module white_blob_third_steering_top #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [wbts_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wbts_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              pix_valid,
	output logic                              pix_ready,
	input  logic [7:0]                        chan_first,
	input  logic [7:0]                        chan_second,
	input  logic [7:0]                        chan_third,
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic [1:0]                        steer_cmd,
	output logic [wbts_pkg::CNT_W-1:0]        left_total,
	output logic [wbts_pkg::CNT_W-1:0]        center_total,
	output logic [wbts_pkg::CNT_W-1:0]        right_total
);

	wbts_pkg::tok_t             tok_s1;
	logic                       adv, fire, s2_free;
	logic [2:0]                 lane_inc;
	logic [wbts_pkg::CNT_W-1:0] left_s2, center_s2, right_s2;

	assign cfg_ready = 1'b1;

	// only the frame's last item needs room in the totals stage
	assign adv  = !tok_s1.last || s2_free;
	assign fire = tok_s1.valid && adv;

	assign lane_inc[0] = tok_s1.white && (tok_s1.region == wbts_pkg::REGION_LEFT);
	assign lane_inc[1] = tok_s1.white && (tok_s1.region == wbts_pkg::REGION_CENTER);
	assign lane_inc[2] = tok_s1.white && (tok_s1.region == wbts_pkg::REGION_RIGHT);

	wbts_scan #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pix_valid   (pix_valid),
		.pix_ready   (pix_ready),
		.chan_first  (chan_first),
		.chan_second (chan_second),
		.chan_third  (chan_third),
		.adv         (adv),
		.tok_s1      (tok_s1)
	);

	wbts_lane u_lane_left (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.inc      (lane_inc[0]),
		.last     (tok_s1.last),
		.total_s2 (left_s2)
	);

	wbts_lane u_lane_center (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.inc      (lane_inc[1]),
		.last     (tok_s1.last),
		.total_s2 (center_s2)
	);

	wbts_lane u_lane_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.inc      (lane_inc[2]),
		.last     (tok_s1.last),
		.total_s2 (right_s2)
	);

	wbts_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (fire && tok_s1.last),
		.left_s2      (left_s2),
		.center_s2    (center_s2),
		.right_s2     (right_s2),
		.s2_free      (s2_free),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.steer_cmd    (steer_cmd),
		.left_total   (left_total),
		.center_total (center_total),
		.right_total  (right_total)
	);

	a_last_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		fire && tok_s1.last |-> s2_free)
		else $error("frame end item fired into an occupied totals stage");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready |=> tok_s1.valid)
		else $error("accepted item lost before the lanes");

	a_one_lane: assert property (@(posedge clk) disable iff (!arst_n)
		tok_s1.valid |-> $onehot0(lane_inc))
		else $error("white pixel counted in more than one band");

endmodule

FILE: design/wbts_scan.sv
module wbts_scan #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [wbts_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wbts_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              pix_valid,
	output logic                              pix_ready,
	input  logic [7:0]                        chan_first,
	input  logic [7:0]                        chan_second,
	input  logic [7:0]                        chan_third,
	input  logic                              adv,
	output wbts_pkg::tok_t                    tok_s1
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int PW = WW + wbts_pkg::RECIP3_W;

	localparam int RST_W = (wbts_pkg::RST_FRAME_WIDTH > MAX_WIDTH) ?
		MAX_WIDTH : wbts_pkg::RST_FRAME_WIDTH;
	localparam int RST_H = (wbts_pkg::RST_FRAME_HEIGHT > MAX_HEIGHT) ?
		MAX_HEIGHT : wbts_pkg::RST_FRAME_HEIGHT;
	localparam int RST_THIRD = RST_W / 3;

	logic [WW-1:0] third_q, two_third_q, wlast_q;
	logic [HW-1:0] hlast_q;
	logic [7:0]    level_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	logic [31:0]   cfg_ext;
	logic [WW-1:0] w_n;
	logic [HW-1:0] h_n;
	logic [PW-1:0] prod;
	logic [WW-1:0] third_n;
	logic          accept, white, row_end, frame_end;
	logic [1:0]    region;

	assign cfg_ext = 32'(cfg_data);

	always_comb begin
		if (cfg_ext == 32'd0) begin
			w_n = WW'(1);
		end else if (cfg_ext > 32'(MAX_WIDTH)) begin
			w_n = WW'(MAX_WIDTH);
		end else begin
			w_n = WW'(cfg_ext);
		end
		if (cfg_ext == 32'd0) begin
			h_n = HW'(1);
		end else if (cfg_ext > 32'(MAX_HEIGHT)) begin
			h_n = HW'(MAX_HEIGHT);
		end else begin
			h_n = HW'(cfg_ext);
		end
	end

	assign prod    = PW'(w_n) * PW'(wbts_pkg::RECIP3);
	assign third_n = WW'(prod >> wbts_pkg::RECIP3_SHIFT);

	// derived frame geometry is worked out once, at the register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			third_q     <= WW'(RST_THIRD);
			two_third_q <= WW'(2 * RST_THIRD);
			wlast_q     <= WW'(RST_W - 1);
			hlast_q     <= HW'(RST_H - 1);
			level_q     <= wbts_pkg::RST_WHITE_LEVEL;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				wbts_pkg::CFG_FRAME_WIDTH: begin
					third_q     <= third_n;
					two_third_q <= WW'({third_n, 1'b0});
					wlast_q     <= w_n - WW'(1);
				end
				wbts_pkg::CFG_FRAME_HEIGHT: begin
					hlast_q <= h_n - HW'(1);
				end
				wbts_pkg::CFG_WHITE_LEVEL: begin
					level_q <= cfg_data[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign pix_ready = !tok_s1.valid || adv;
	assign accept    = pix_valid && pix_ready;

	assign white = (chan_first == level_q) && (chan_second == level_q) &&
		(chan_third == level_q);

	always_comb begin
		if (WW'(col_q) < third_q) begin
			region = wbts_pkg::REGION_LEFT;
		end else if (WW'(col_q) > two_third_q) begin
			region = wbts_pkg::REGION_RIGHT;
		end else begin
			region = wbts_pkg::REGION_CENTER;
		end
	end

	// a size shrunk mid-frame ends the row or frame at once
	assign row_end   = (WW'(col_q) >= wlast_q);
	assign frame_end = row_end && (HW'(row_q) >= hlast_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
		end else if (accept) begin
			tok_s1.valid  <= 1'b1;
			tok_s1.white  <= white;
			tok_s1.region <= region;
			tok_s1.last   <= frame_end;
		end else if (adv) begin
			tok_s1.valid <= 1'b0;
		end
	end

endmodule

FILE: design/wbts_lane.sv
module wbts_lane (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  logic                         inc,
	input  logic                         last,
	output logic [wbts_pkg::CNT_W-1:0]   total_s2
);

	logic [wbts_pkg::CNT_W-1:0] acc_q;
	logic [wbts_pkg::CNT_W-1:0] acc_nxt;

	// saturating count
	assign acc_nxt = (inc && (acc_q != wbts_pkg::CNT_MAX)) ?
		acc_q + wbts_pkg::CNT_W'(1) : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (fire) begin
			acc_q <= last ? '0 : acc_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && last) begin
			total_s2 <= acc_nxt;
		end
	end

endmodule

FILE: design/wbts_merge.sv
module wbts_merge (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  logic [wbts_pkg::CNT_W-1:0]   left_s2,
	input  logic [wbts_pkg::CNT_W-1:0]   center_s2,
	input  logic [wbts_pkg::CNT_W-1:0]   right_s2,
	output logic                         s2_free,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [1:0]                   steer_cmd,
	output logic [wbts_pkg::CNT_W-1:0]   left_total,
	output logic [wbts_pkg::CNT_W-1:0]   center_total,
	output logic [wbts_pkg::CNT_W-1:0]   right_total
);

	logic       valid_s2;
	logic       s2_move;
	logic [1:0] cmd;

	assign s2_move = valid_s2 && (!res_valid || res_ready);
	assign s2_free = !valid_s2 || s2_move;

	always_comb begin
		if ((left_s2 == '0) && (center_s2 == '0) && (right_s2 == '0)) begin
			cmd = wbts_pkg::CMD_STOP;
		end else if ((left_s2 > right_s2) && (left_s2 > center_s2)) begin
			cmd = wbts_pkg::CMD_LEFT;
		end else if ((right_s2 > left_s2) && (right_s2 > center_s2)) begin
			cmd = wbts_pkg::CMD_RIGHT;
		end else begin
			cmd = wbts_pkg::CMD_FORWARD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			if (load) begin
				valid_s2 <= 1'b1;
			end else if (s2_move) begin
				valid_s2 <= 1'b0;
			end
			if (s2_move) begin
				res_valid <= 1'b1;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move) begin
			steer_cmd    <= cmd;
			left_total   <= left_s2;
			center_total <= center_s2;
			right_total  <= right_s2;
		end
	end

	a_stop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((steer_cmd == wbts_pkg::CMD_STOP) ==
			((left_total == '0) && (center_total == '0) && (right_total == '0))))
		else $error("stop command does not match empty totals");

	a_left_wins: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (steer_cmd == wbts_pkg::CMD_LEFT) |->
			(left_total > center_total) && (left_total > right_total))
		else $error("left command without a strict left majority");

	a_right_wins: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (steer_cmd == wbts_pkg::CMD_RIGHT) |->
			(right_total > center_total) && (right_total > left_total))
		else $error("right command without a strict right majority");

endmodule

FILE: test/white_blob_third_steering_top_tb.sv
module white_blob_third_steering_top_tb;

	localparam int MAX_W = 2048;
	localparam int MAX_H = 2048;

	typedef struct packed {
		logic [1:0]                 cmd;
		logic [wbts_pkg::CNT_W-1:0] left;
		logic [wbts_pkg::CNT_W-1:0] center;
		logic [wbts_pkg::CNT_W-1:0] right;
	} steer_res_t;

	typedef struct {
		logic [7:0]  a;
		logic [7:0]  b;
		logic [7:0]  c;
		int unsigned gap;
	} pixel_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [wbts_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [wbts_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                            pix_valid = 1'b0;
	logic                            pix_ready;
	logic [7:0]                      chan_first = '0;
	logic [7:0]                      chan_second = '0;
	logic [7:0]                      chan_third = '0;
	logic                            res_valid;
	logic                            res_ready = 1'b0;
	logic [1:0]                      steer_cmd;
	logic [wbts_pkg::CNT_W-1:0]      left_total;
	logic [wbts_pkg::CNT_W-1:0]      center_total;
	logic [wbts_pkg::CNT_W-1:0]      right_total;

	white_blob_third_steering_top #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pix_valid(pix_valid),
		.pix_ready(pix_ready),
		.chan_first(chan_first),
		.chan_second(chan_second),
		.chan_third(chan_third),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.steer_cmd(steer_cmd),
		.left_total(left_total),
		.center_total(center_total),
		.right_total(right_total)
	);

	// scene tracker state, mirrors the block
	int unsigned                m_width_reg;
	int unsigned                m_height_reg;
	logic [7:0]                 m_white;
	int unsigned                m_col;
	int unsigned                m_row;
	logic [wbts_pkg::CNT_W-1:0] m_left;
	logic [wbts_pkg::CNT_W-1:0] m_center;
	logic [wbts_pkg::CNT_W-1:0] m_right;

	pixel_t      pixel_q[$];
	steer_res_t  steer_q[$];
	int unsigned pix_total = 0;
	int unsigned pix_sent = 0;
	int unsigned steer_made = 0;
	int unsigned steer_got = 0;
	int unsigned fail_cnt = 0;

	int unsigned tx_wait = 0;
	int unsigned tx_calm = 0;
	int unsigned rx_wait = 0;
	int unsigned rx_calm = 0;
	pixel_t      tx_next;
	steer_res_t  rx_want;
	steer_res_t  tx_res;

	logic        hold_req = 1'b0;
	logic        hold_used = 1'b0;
	int unsigned hold_left = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned top);
		if (v == 0)
			return 1;
		if (v > top)
			return top;
		return v;
	endfunction

	function automatic logic [wbts_pkg::CNT_W-1:0] bump(
			input logic [wbts_pkg::CNT_W-1:0] cnt);
		return (cnt == wbts_pkg::CNT_MAX) ? cnt : cnt + 1'b1;
	endfunction

	// one pixel through the tracker; returns 1 when it closes a frame
	function automatic bit track_pixel(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c, output steer_res_t res);
		int unsigned w;
		int unsigned h;
		int unsigned third;
		bit row_end;
		w = clamp_dim(m_width_reg, MAX_W);
		h = clamp_dim(m_height_reg, MAX_H);
		third = w / 3;
		res = '0;
		if (a == m_white && b == m_white && c == m_white) begin
			if (m_col < third)
				m_left = bump(m_left);
			else if (m_col > 2 * third)
				m_right = bump(m_right);
			else
				m_center = bump(m_center);
		end
		row_end = (m_col >= w - 1);
		if (!(row_end && m_row >= h - 1)) begin
			if (row_end) begin
				m_col = 0;
				m_row++;
			end else begin
				m_col++;
			end
			return 1'b0;
		end
		if (m_left == 0 && m_center == 0 && m_right == 0)
			res.cmd = wbts_pkg::CMD_STOP;
		else if (m_left > m_right && m_left > m_center)
			res.cmd = wbts_pkg::CMD_LEFT;
		else if (m_right > m_left && m_right > m_center)
			res.cmd = wbts_pkg::CMD_RIGHT;
		else
			res.cmd = wbts_pkg::CMD_FORWARD;
		res.left = m_left;
		res.center = m_center;
		res.right = m_right;
		m_col = 0;
		m_row = 0;
		m_left = '0;
		m_center = '0;
		m_right = '0;
		return 1'b1;
	endfunction

	function automatic void check_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
			fail_cnt++;
		end
	endfunction

	// sender gap per item, with runs of back-to-back items
	function automatic int unsigned next_gap();
		if (tx_calm != 0) begin
			tx_calm--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			tx_calm = $urandom_range(8, 30);
			return 0;
		end
		if ($urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 12);
	endfunction

	function automatic pixel_t make_pixel(input int unsigned pct, input bit quick);
		pixel_t p;
		int unsigned r;
		r = $urandom_range(0, 99);
		p.a = m_white;
		p.b = m_white;
		p.c = m_white;
		if (r >= pct) begin
			if (r < pct + 20) begin
				// near miss: one channel off the white level
				case ($urandom_range(0, 2))
					0: p.a = m_white ^ 8'($urandom_range(1, 255));
					1: p.b = m_white ^ 8'($urandom_range(1, 255));
					default: p.c = m_white ^ 8'($urandom_range(1, 255));
				endcase
			end else begin
				p.a = 8'($urandom);
				p.b = 8'($urandom);
				p.c = 8'($urandom);
			end
		end
		p.gap = quick ? 0 : next_gap();
		return p;
	endfunction

	task automatic enqueue(input pixel_t p);
		pixel_q.push_back(p);
		pix_total++;
	endtask

	task automatic queue_one(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
		pixel_t p;
		p.a = a;
		p.b = b;
		p.c = c;
		p.gap = next_gap();
		enqueue(p);
	endtask

	task automatic queue_pixels(input int unsigned n);
		repeat (n) enqueue(make_pixel(30, 1'b0));
	endtask

	// whole frames at the current size, each with one favoured band or none
	task automatic queue_frames(input int unsigned n, input bit quick);
		int unsigned w;
		int unsigned h;
		int unsigned third;
		int unsigned col;
		int unsigned band;
		int unsigned hot;
		int unsigned pct;
		w = clamp_dim(m_width_reg, MAX_W);
		h = clamp_dim(m_height_reg, MAX_H);
		third = w / 3;
		repeat (n) begin
			hot = $urandom_range(0, 4);
			for (int unsigned i = 0; i < w * h; i++) begin
				col = i % w;
				band = (col < third) ? 0 : (col > 2 * third) ? 2 : 1;
				if (hot == 4)
					pct = 0;
				else if (hot == 3)
					pct = 30;
				else
					pct = (band == hot) ? 60 : 10;
				enqueue(make_pixel(pct, quick));
			end
		end
	endtask

	// all pixels taken, all results in, then let the pipeline drain
	task automatic settle();
		do @(posedge clk); while (pix_sent != pix_total || steer_got != steer_made);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [wbts_pkg::CFG_IDX_W-1:0] idx,
			input logic [wbts_pkg::CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			wbts_pkg::CFG_FRAME_WIDTH: m_width_reg = val;
			wbts_pkg::CFG_FRAME_HEIGHT: m_height_reg = val;
			wbts_pkg::CFG_WHITE_LEVEL: m_white = val[7:0];
			default: ;
		endcase
	endtask

	// called at a rising edge, returns at one
	task automatic configure(input int unsigned w, input int unsigned h, input logic [7:0] wl);
		write_reg(wbts_pkg::CFG_FRAME_WIDTH, wbts_pkg::CFG_DATA_W'(w));
		write_reg(wbts_pkg::CFG_FRAME_HEIGHT, wbts_pkg::CFG_DATA_W'(h));
		write_reg(wbts_pkg::CFG_WHITE_LEVEL, {4'($urandom), wl});
		if ($urandom_range(0, 3) == 0)
			write_reg(wbts_pkg::CFG_IDX_W'(3), wbts_pkg::CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
		end else begin
			if (pix_valid && pix_ready) begin
				if (track_pixel(chan_first, chan_second, chan_third, tx_res)) begin
					steer_q.push_back(tx_res);
					steer_made <= steer_made + 1;
				end
				pix_sent <= pix_sent + 1;
			end
			if (!pix_valid || pix_ready) begin
				if (pixel_q.size() != 0 && tx_wait >= pixel_q[0].gap) begin
					tx_next = pixel_q.pop_front();
					chan_first <= tx_next.a;
					chan_second <= tx_next.b;
					chan_third <= tx_next.c;
					pix_valid <= 1'b1;
					tx_wait = 0;
				end else begin
					pix_valid <= 1'b0;
					if (pixel_q.size() != 0)
						tx_wait++;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				if (steer_q.size() == 0) begin
					$display("%0t: result with nothing expected, actual cmd %0d totals %0d %0d %0d",
						$time, steer_cmd, left_total, center_total, right_total);
					fail_cnt++;
				end else begin
					rx_want = steer_q.pop_front();
					check_field("steer_cmd", rx_want.cmd, steer_cmd);
					check_field("left_total", rx_want.left, left_total);
					check_field("center_total", rx_want.center, center_total);
					check_field("right_total", rx_want.right, right_total);
					steer_got <= steer_got + 1;
				end
				if (rx_calm != 0) begin
					rx_calm--;
					rx_wait = 0;
				end else if ($urandom_range(0, 15) == 0) begin
					rx_calm = $urandom_range(5, 15);
					rx_wait = 0;
				end else begin
					rx_wait = $urandom_range(0, 12);
				end
			end else if (rx_wait != 0) begin
				rx_wait--;
			end
			res_ready <= (rx_wait == 0) && (hold_left == 0);
		end
	end

	// long receiver hold-off so that finished frames pile up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_used <= 1'b0;
		end else if (hold_req && !hold_used) begin
			hold_left <= 300;
			hold_used <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	initial begin
		int unsigned base;
		int unsigned w;
		int unsigned h;
		logic [7:0] wl;
		m_width_reg = wbts_pkg::RST_FRAME_WIDTH;
		m_height_reg = wbts_pkg::RST_FRAME_HEIGHT;
		m_white = wbts_pkg::RST_WHITE_LEVEL;
		m_col = 0;
		m_row = 0;
		m_left = '0;
		m_center = '0;
		m_right = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// two white pixels at the reset frame size, then the row is cut short
		@(negedge clk);
		queue_one(8'd255, 8'd255, 8'd255);
		queue_one(8'd255, 8'd255, 8'd255);
		settle();
		configure(4, 1, 8'd255);
		@(negedge clk);
		queue_one(8'd0, 8'd255, 8'd255);
		queue_one(8'd255, 8'd0, 8'd255);
		// right band only
		queue_one(8'd0, 8'd0, 8'd0);
		queue_one(8'd0, 8'd255, 8'd255);
		queue_one(8'd255, 8'd0, 8'd255);
		queue_one(8'd255, 8'd255, 8'd255);
		// centre incl. column at twice the third beats right
		queue_one(8'd255, 8'd255, 8'd0);
		queue_one(8'd255, 8'd255, 8'd255);
		queue_one(8'd255, 8'd255, 8'd255);
		queue_one(8'd255, 8'd255, 8'd255);
		// left and right tie
		queue_one(8'd255, 8'd255, 8'd255);
		queue_one(8'd0, 8'd0, 8'd0);
		queue_one(8'd0, 8'd0, 8'd0);
		queue_one(8'd255, 8'd255, 8'd255);
		// nothing white
		queue_one(8'd0, 8'd255, 8'd255);
		queue_one(8'd255, 8'd0, 8'd255);
		queue_one(8'd255, 8'd255, 8'd0);
		queue_one(8'd0, 8'd0, 8'd0);
		settle();
		// zero sizes act as one pixel per frame
		configure(0, 0, 8'd255);
		@(negedge clk);
		queue_one(8'd255, 8'd255, 8'd255);
		queue_one(8'd255, 8'd255, 8'd254);
		settle();
		configure(0, 1, 8'd0);
		@(negedge clk);
		queue_one(8'd0, 8'd0, 8'd0);
		queue_one(8'd0, 8'd0, 8'd1);
		settle();

		// oversized width clamps, past the clamped third, then the row is cut short
		configure(4095, 1, 8'd255);
		@(negedge clk);
		queue_pixels(700);
		settle();
		configure(1, 1, 8'd255);
		@(negedge clk);
		queue_one(8'd255, 8'd255, 8'd255);
		settle();
		// tallest frame, then the height drops mid-frame
		configure(1, 4095, 8'd255);
		@(negedge clk);
		queue_pixels(100);
		settle();
		configure(3, 0, 8'd255);
		@(negedge clk);
		queue_pixels(3);
		settle();
		// column already past the new last column
		configure(8, 4, 8'($urandom));
		@(negedge clk);
		queue_pixels(13);
		settle();
		configure(4, 2, m_white);
		@(negedge clk);
		queue_pixels(1);
		queue_frames(2, 1'b0);
		settle();
		// receiver holds off while pixels keep coming back to back
		configure(3, 2, 8'd255);
		hold_req <= 1'b1;
		@(negedge clk);
		queue_frames(25, 1'b1);
		settle();

		base = pix_total;
		while (pix_total < base + 350) begin
			case ($urandom_range(0, 9))
				0: w = 0;
				1: w = $urandom_range(9, 60);
				2: w = $urandom_range(1, 3);
				default: w = $urandom_range(1, 8);
			endcase
			h = (w > 8) ? $urandom_range(0, 1) : $urandom_range(0, 4);
			case ($urandom_range(0, 4))
				0: wl = 8'd255;
				1: wl = 8'd0;
				default: wl = 8'($urandom);
			endcase
			configure(w, h, wl);
			@(negedge clk);
			queue_frames($urandom_range(2, 6), 1'b0);
			settle();
		end

		if (fail_cnt == 0)
			$display("white_blob_third_steering_top verification clean");
		else
			$display("white_blob_third_steering_top verification failed");
		$finish;
	end

	initial begin
		#4000000;
		$display("white_blob_third_steering_top verification failed");
		$finish;
	end

endmodule
